// File: sv/phast_pkg.sv
// Shared types, constants and helpers of the contracted-graph distance engine.
package phast_pkg;

    localparam int MAX_NODES   = 1024;
    localparam int NODE_W      = 10;
    localparam int NODE_ID_W   = 11;
    localparam int MAX_EDGES   = 4096;
    localparam int EDGE_W      = 12;
    localparam int OFF_W       = 13;
    localparam int MAX_TARGETS = 64;
    localparam int TPOS_W      = 6;
    localparam int TCNT_W      = 7;
    localparam int WEIGHT_W    = 32;
    localparam int DIST_W      = 40;
    localparam int HEAP_CAP    = MAX_EDGES + 1;
    localparam int HEAP_AW     = 13;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 11;

    localparam logic [DIST_W-1:0] DIST_INF = '1;
    localparam logic [DIST_W-1:0] DIST_CAP = DIST_INF - 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_COUNT = 1'd1;

    typedef enum logic [2:0] {
        KIND_UP_OFFSET   = 3'd0,
        KIND_UP_EDGE     = 3'd1,
        KIND_DOWN_OFFSET = 3'd2,
        KIND_DOWN_EDGE   = 3'd3,
        KIND_TARGET      = 3'd4,
        KIND_QUERY       = 3'd5
    } kind_t;

    typedef struct packed {
        logic [2:0]           kind;
        logic [NODE_ID_W-1:0] node_id;
        logic [OFF_W-1:0]     edge_offset;
        logic [EDGE_W-1:0]    edge_slot;
        logic [NODE_W-1:0]    neighbor;
        logic [WEIGHT_W-1:0]  weight;
        logic [TPOS_W-1:0]    target_pos;
        logic [NODE_W-1:0]    target_node;
        logic [NODE_W-1:0]    source_node;
    } item_t;

    typedef struct packed {
        logic [TPOS_W-1:0] result_pos;
        logic [DIST_W-1:0] distance;
        logic              unreachable;
        logic              last;
    } result_t;

    typedef struct packed {
        logic [DIST_W-1:0] key;
        logic [NODE_W-1:0] node;
    } heap_ent_t;

    typedef struct packed {
        logic [NODE_W-1:0]   node;
        logic [WEIGHT_W-1:0] weight;
    } edge_ent_t;

    typedef enum logic [4:0] {
        OP_NONE, OP_LOAD, OP_CLEAR, OP_INIT,
        OP_POP0, OP_POP1, OP_POP2,
        OP_SD0, OP_SD1, OP_SD2, OP_SD3,
        OP_DV0, OP_DV1, OP_UO0, OP_UO1, OP_UO2,
        OP_E0, OP_E1, OP_E2, OP_PU0, OP_PU1,
        OP_SW0, OP_SW1, OP_SW2, OP_D0, OP_D1, OP_D2,
        OP_T0, OP_T1, OP_T2
    } op_t;

    typedef enum logic [4:0] {
        S_IDLE, S_CLEAR, S_INIT,
        S_POP0, S_POP1, S_POP2,
        S_SD0, S_SD1, S_SD2, S_SD3,
        S_DV0, S_DV1, S_UO0, S_UO1, S_UO2,
        S_E0, S_E1, S_E2, S_PU0, S_PU1,
        S_SW0, S_SW1, S_SW2, S_D0, S_D1, S_D2,
        S_T0, S_T1, S_T2
    } state_t;

    typedef struct packed {
        op_t op;
    } cmd_t;

    typedef struct packed {
        logic is_query;
        logic heap_empty;
        logic sd_leaf;
        logic sd_hasr;
        logic sd_stop;
        logic stale;
        logic edge_end;
        logic foreign;
        logic go_push;
        logic at_root;
        logic parent_gt;
        logic node_end;
        logic tgt_end;
        logic clr_done;
    } status_t;

    function automatic logic [DIST_W-1:0] sat_add(input logic [DIST_W-1:0] a,
                                                  input logic [WEIGHT_W-1:0] w);
        logic [DIST_W:0] s;
        s = {1'b0, a} + {{(DIST_W + 1 - WEIGHT_W){1'b0}}, w};
        return (s > {1'b0, DIST_CAP}) ? DIST_CAP : s[DIST_W-1:0];
    endfunction

endpackage

// File: sv/phast_one_to_many_shortest_path_top.sv
// Top level of the contracted-graph one-to-many distance engine.
// Loads (offsets, edges, targets) leave the block idle. A query runs an upward
// heap search, then a downward sweep over node_count nodes, then reports
// target_count results (counts clamped to 1..1024 and 1..64), then refills all
// 1024 distance entries with infinity; the same clearing pass runs after reset,
// with busy high. Each query step is paced by the single read port of each
// memory. Results appear as one-cycle strobes on result_valid and cannot be
// held off.
module phast_one_to_many_shortest_path_top (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  phast_pkg::item_t                 item,
    output phast_pkg::result_t               result,
    output logic                             result_valid,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [phast_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [phast_pkg::CFG_DATA_W-1:0] cfg_data
);

    phast_pkg::cmd_t    cmd;
    phast_pkg::status_t status;

    phast_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    phast_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .item         (item),
        .cmd          (cmd),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cfg_ready    (cfg_ready),
        .status       (status),
        .result       (result),
        .result_valid (result_valid)
    );

    // Results only come out while a query is still in progress.
    assert property (@(posedge clk) disable iff (!rst_n) result_valid |-> busy)
        else $error("result strobe outside a query");

    // A load transfer leaves the block idle in the following cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && item.kind != phast_pkg::KIND_QUERY) |=> !busy)
        else $error("load did not return to idle");

    // An unreachable target always reports a zero distance.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.unreachable) |-> (result.distance == '0))
        else $error("unreachable result with nonzero distance");

endmodule

// File: sv/phast_ctrl.sv
// Sequencer of the load, search, sweep, report and clear phases.
module phast_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  phast_pkg::status_t status,
    output phast_pkg::cmd_t    cmd,
    output logic               busy
);

    phast_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= phast_pkg::S_CLEAR;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = phast_pkg::OP_NONE;
        unique case (state_reg)
            phast_pkg::S_IDLE:
            begin
                if (start)
                begin
                    cmd.op = phast_pkg::OP_LOAD;
                    if (status.is_query)
                        state_next = phast_pkg::S_INIT;
                end
            end
            phast_pkg::S_CLEAR:
            begin
                cmd.op = phast_pkg::OP_CLEAR;
                if (status.clr_done)
                    state_next = phast_pkg::S_IDLE;
            end
            phast_pkg::S_INIT:
            begin
                cmd.op     = phast_pkg::OP_INIT;
                state_next = phast_pkg::S_POP0;
            end
            phast_pkg::S_POP0:
            begin
                cmd.op     = phast_pkg::OP_POP0;
                state_next = status.heap_empty ? phast_pkg::S_SW0 : phast_pkg::S_POP1;
            end
            phast_pkg::S_POP1:
            begin
                cmd.op     = phast_pkg::OP_POP1;
                state_next = phast_pkg::S_POP2;
            end
            phast_pkg::S_POP2:
            begin
                cmd.op     = phast_pkg::OP_POP2;
                state_next = phast_pkg::S_SD0;
            end
            phast_pkg::S_SD0:
            begin
                cmd.op     = phast_pkg::OP_SD0;
                state_next = status.sd_leaf ? phast_pkg::S_DV0 : phast_pkg::S_SD1;
            end
            phast_pkg::S_SD1:
            begin
                cmd.op     = phast_pkg::OP_SD1;
                state_next = status.sd_hasr ? phast_pkg::S_SD2 : phast_pkg::S_SD3;
            end
            phast_pkg::S_SD2:
            begin
                cmd.op     = phast_pkg::OP_SD2;
                state_next = phast_pkg::S_SD3;
            end
            phast_pkg::S_SD3:
            begin
                cmd.op     = phast_pkg::OP_SD3;
                state_next = status.sd_stop ? phast_pkg::S_DV0 : phast_pkg::S_SD0;
            end
            phast_pkg::S_DV0:
            begin
                cmd.op     = phast_pkg::OP_DV0;
                state_next = phast_pkg::S_DV1;
            end
            phast_pkg::S_DV1:
            begin
                cmd.op     = phast_pkg::OP_DV1;
                state_next = status.stale ? phast_pkg::S_POP0 : phast_pkg::S_UO0;
            end
            phast_pkg::S_UO0:
            begin
                cmd.op     = phast_pkg::OP_UO0;
                state_next = phast_pkg::S_UO1;
            end
            phast_pkg::S_UO1:
            begin
                cmd.op     = phast_pkg::OP_UO1;
                state_next = phast_pkg::S_UO2;
            end
            phast_pkg::S_UO2:
            begin
                cmd.op     = phast_pkg::OP_UO2;
                state_next = phast_pkg::S_E0;
            end
            phast_pkg::S_E0:
            begin
                cmd.op     = phast_pkg::OP_E0;
                state_next = status.edge_end ? phast_pkg::S_POP0 : phast_pkg::S_E1;
            end
            phast_pkg::S_E1:
            begin
                cmd.op     = phast_pkg::OP_E1;
                state_next = status.foreign ? phast_pkg::S_E0 : phast_pkg::S_E2;
            end
            phast_pkg::S_E2:
            begin
                cmd.op     = phast_pkg::OP_E2;
                state_next = status.go_push ? phast_pkg::S_PU0 : phast_pkg::S_E0;
            end
            phast_pkg::S_PU0:
            begin
                cmd.op     = phast_pkg::OP_PU0;
                state_next = status.at_root ? phast_pkg::S_E0 : phast_pkg::S_PU1;
            end
            phast_pkg::S_PU1:
            begin
                cmd.op     = phast_pkg::OP_PU1;
                state_next = status.parent_gt ? phast_pkg::S_PU0 : phast_pkg::S_E0;
            end
            phast_pkg::S_SW0:
            begin
                cmd.op     = phast_pkg::OP_SW0;
                state_next = status.node_end ? phast_pkg::S_T0 : phast_pkg::S_SW1;
            end
            phast_pkg::S_SW1:
            begin
                cmd.op     = phast_pkg::OP_SW1;
                state_next = phast_pkg::S_SW2;
            end
            phast_pkg::S_SW2:
            begin
                cmd.op     = phast_pkg::OP_SW2;
                state_next = phast_pkg::S_D0;
            end
            phast_pkg::S_D0:
            begin
                cmd.op     = phast_pkg::OP_D0;
                state_next = status.edge_end ? phast_pkg::S_SW0 : phast_pkg::S_D1;
            end
            phast_pkg::S_D1:
            begin
                cmd.op     = phast_pkg::OP_D1;
                state_next = status.foreign ? phast_pkg::S_D0 : phast_pkg::S_D2;
            end
            phast_pkg::S_D2:
            begin
                cmd.op     = phast_pkg::OP_D2;
                state_next = phast_pkg::S_D0;
            end
            phast_pkg::S_T0:
            begin
                cmd.op     = phast_pkg::OP_T0;
                state_next = status.tgt_end ? phast_pkg::S_CLEAR : phast_pkg::S_T1;
            end
            phast_pkg::S_T1:
            begin
                cmd.op     = phast_pkg::OP_T1;
                state_next = status.foreign ? phast_pkg::S_T0 : phast_pkg::S_T2;
            end
            phast_pkg::S_T2:
            begin
                cmd.op     = phast_pkg::OP_T2;
                state_next = phast_pkg::S_T0;
            end
            default:
            begin
                state_next = phast_pkg::S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != phast_pkg::S_IDLE);

endmodule

// File: sv/phast_dp.sv
// Datapath: graph, target, distance and heap memories with their index registers.
module phast_dp (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  phast_pkg::item_t                    item,
    input  phast_pkg::cmd_t                     cmd,
    input  logic                                cfg_valid,
    input  logic [phast_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [phast_pkg::CFG_DATA_W-1:0]    cfg_data,
    output logic                                cfg_ready,
    output phast_pkg::status_t                  status,
    output phast_pkg::result_t                  result,
    output logic                                result_valid
);

    // Memories.
    logic [phast_pkg::OFF_W-1:0] up_off_mem [phast_pkg::MAX_NODES+1];
    logic [phast_pkg::OFF_W-1:0] dn_off_mem [phast_pkg::MAX_NODES+1];
    phast_pkg::edge_ent_t        up_edge_mem [phast_pkg::MAX_EDGES];
    phast_pkg::edge_ent_t        dn_edge_mem [phast_pkg::MAX_EDGES];
    logic [phast_pkg::NODE_W-1:0] tgt_mem [phast_pkg::MAX_TARGETS];
    logic [phast_pkg::DIST_W-1:0] dist_mem [phast_pkg::MAX_NODES];
    phast_pkg::heap_ent_t        heap_mem [phast_pkg::HEAP_CAP];

    logic                            up_off_we, dn_off_we, up_edge_we, dn_edge_we, tgt_we;
    logic [phast_pkg::NODE_ID_W-1:0] up_off_ra, dn_off_ra;
    logic [phast_pkg::OFF_W-1:0]     up_off_rd, dn_off_rd;
    logic [phast_pkg::EDGE_W-1:0]    up_edge_ra, dn_edge_ra;
    phast_pkg::edge_ent_t            up_edge_rd, dn_edge_rd;
    logic [phast_pkg::TPOS_W-1:0]    tgt_ra;
    logic [phast_pkg::NODE_W-1:0]    tgt_rd;
    logic                            dist_we;
    logic [phast_pkg::NODE_W-1:0]    dist_wa, dist_ra;
    logic [phast_pkg::DIST_W-1:0]    dist_wd, dist_rd;
    logic                            heap_we;
    logic [phast_pkg::HEAP_AW-1:0]   heap_wa, heap_ra;
    phast_pkg::heap_ent_t            heap_wd, heap_rd;

    // Registers.
    logic [phast_pkg::NODE_ID_W-1:0] node_count_reg, n_reg;
    logic [phast_pkg::TCNT_W-1:0]    target_count_reg, tc_reg, k_reg;
    logic [phast_pkg::NODE_W-1:0]    src_reg, v_reg, eh_reg, clr_reg;
    logic [phast_pkg::HEAP_AW-1:0]   hsize_reg, hi_reg;
    logic [phast_pkg::DIST_W-1:0]    hk_reg, wkey_reg, dv_reg, di_reg;
    logic [phast_pkg::NODE_W-1:0]    hn_reg;
    logic [phast_pkg::OFF_W-1:0]     e_reg, ee_reg;
    logic [phast_pkg::WEIGHT_W-1:0]  ew_reg;
    phast_pkg::heap_ent_t            cl_reg, cr_reg;
    logic                            hasr_reg;
    logic [phast_pkg::NODE_ID_W-1:0] sw_reg;
    phast_pkg::result_t              res_reg;
    logic                            res_valid_reg;

    // Shared combinational terms.
    logic [phast_pkg::HEAP_AW:0]     l_w, r_w;
    logic [phast_pkg::HEAP_AW-1:0]   p_w;
    logic [phast_pkg::OFF_W-1:0]     end_w;
    logic [phast_pkg::DIST_W-1:0]    c_up, c_dn, dt_w;
    logic                            pick_l, pick_r;
    logic [phast_pkg::NODE_ID_W-1:0] clamp_n;
    logic [phast_pkg::TCNT_W-1:0]    clamp_tc;

    assign cfg_ready    = 1'b1;
    assign result       = res_reg;
    assign result_valid = res_valid_reg;

    assign l_w   = {hi_reg, 1'b1};
    assign r_w   = l_w + 1'b1;
    assign p_w   = (hi_reg - 1'b1) >> 1;
    assign end_w = (cmd.op == phast_pkg::OP_UO2) ? up_off_rd : dn_off_rd;
    assign c_up  = phast_pkg::sat_add(dv_reg, ew_reg);
    // A downward edge from the node being swept reads its running value.
    assign dt_w  = (eh_reg == sw_reg[phast_pkg::NODE_W-1:0]) ? di_reg : dist_rd;
    assign c_dn  = phast_pkg::sat_add(dt_w, ew_reg);

    assign pick_l = (cl_reg.key < hk_reg);
    assign pick_r = hasr_reg && (cr_reg.key < (pick_l ? cl_reg.key : hk_reg));

    assign clamp_n  = (node_count_reg == '0) ? phast_pkg::NODE_ID_W'(1) :
                      (node_count_reg > phast_pkg::NODE_ID_W'(phast_pkg::MAX_NODES)) ?
                      phast_pkg::NODE_ID_W'(phast_pkg::MAX_NODES) : node_count_reg;
    assign clamp_tc = (target_count_reg == '0) ? phast_pkg::TCNT_W'(1) :
                      (target_count_reg > phast_pkg::TCNT_W'(phast_pkg::MAX_TARGETS)) ?
                      phast_pkg::TCNT_W'(phast_pkg::MAX_TARGETS) : target_count_reg;

    always_comb
    begin
        status.is_query   = (item.kind == phast_pkg::KIND_QUERY);
        status.heap_empty = (hsize_reg == '0);
        status.sd_leaf    = (l_w >= {1'b0, hsize_reg});
        status.sd_hasr    = (r_w < {1'b0, hsize_reg});
        status.sd_stop    = !pick_l && !pick_r;
        status.stale      = (wkey_reg > dist_rd);
        status.edge_end   = (e_reg >= ee_reg);
        status.foreign    = 1'b0;
        unique case (cmd.op)
            phast_pkg::OP_E1: status.foreign = ({1'b0, up_edge_rd.node} >= n_reg);
            phast_pkg::OP_D1: status.foreign = ({1'b0, dn_edge_rd.node} >= n_reg);
            phast_pkg::OP_T1: status.foreign = ({1'b0, tgt_rd} >= n_reg);
            default:          status.foreign = 1'b0;
        endcase
        status.go_push    = (c_up < dist_rd) &&
                            (hsize_reg < phast_pkg::HEAP_AW'(phast_pkg::HEAP_CAP));
        status.at_root    = (hi_reg == '0);
        status.parent_gt  = (heap_rd.key > hk_reg);
        status.node_end   = (sw_reg >= n_reg);
        status.tgt_end    = (k_reg >= tc_reg);
        status.clr_done   = (clr_reg == '1);
    end

    // Memory addresses and write ports.
    always_comb
    begin
        up_off_we  = 1'b0;
        dn_off_we  = 1'b0;
        up_edge_we = 1'b0;
        dn_edge_we = 1'b0;
        tgt_we     = 1'b0;
        up_off_ra  = {1'b0, v_reg};
        dn_off_ra  = sw_reg;
        up_edge_ra = e_reg[phast_pkg::EDGE_W-1:0];
        dn_edge_ra = e_reg[phast_pkg::EDGE_W-1:0];
        tgt_ra     = k_reg[phast_pkg::TPOS_W-1:0];
        dist_we    = 1'b0;
        dist_wa    = eh_reg;
        dist_wd    = c_up;
        dist_ra    = v_reg;
        heap_we    = 1'b0;
        heap_wa    = hi_reg;
        heap_wd    = '{key: hk_reg, node: hn_reg};
        heap_ra    = '0;
        unique case (cmd.op)
            phast_pkg::OP_LOAD:
            begin
                up_off_we  = (item.kind == phast_pkg::KIND_UP_OFFSET) &&
                             (item.node_id <= phast_pkg::NODE_ID_W'(phast_pkg::MAX_NODES));
                dn_off_we  = (item.kind == phast_pkg::KIND_DOWN_OFFSET) &&
                             (item.node_id <= phast_pkg::NODE_ID_W'(phast_pkg::MAX_NODES));
                up_edge_we = (item.kind == phast_pkg::KIND_UP_EDGE);
                dn_edge_we = (item.kind == phast_pkg::KIND_DOWN_EDGE);
                tgt_we     = (item.kind == phast_pkg::KIND_TARGET);
            end
            phast_pkg::OP_CLEAR:
            begin
                dist_we = 1'b1;
                dist_wa = clr_reg;
                dist_wd = phast_pkg::DIST_INF;
            end
            phast_pkg::OP_INIT:
            begin
                dist_we = ({1'b0, src_reg} < n_reg);
                dist_wa = src_reg;
                dist_wd = '0;
                heap_we = dist_we;
                heap_wa = '0;
                heap_wd = '{key: '0, node: src_reg};
            end
            phast_pkg::OP_POP1: heap_ra = hsize_reg - 1'b1;
            phast_pkg::OP_SD0:
            begin
                heap_ra = l_w[phast_pkg::HEAP_AW-1:0];
                heap_we = status.sd_leaf;
            end
            phast_pkg::OP_SD1: heap_ra = r_w[phast_pkg::HEAP_AW-1:0];
            phast_pkg::OP_SD3:
            begin
                heap_we = 1'b1;
                if (pick_r)
                    heap_wd = cr_reg;
                else if (pick_l)
                    heap_wd = cl_reg;
            end
            phast_pkg::OP_UO1: up_off_ra = {1'b0, v_reg} + 1'b1;
            phast_pkg::OP_E1:  dist_ra = up_edge_rd.node;
            phast_pkg::OP_E2:  dist_we = (c_up < dist_rd);
            phast_pkg::OP_PU0:
            begin
                heap_ra = p_w;
                heap_we = status.at_root;
            end
            phast_pkg::OP_PU1:
            begin
                heap_we = 1'b1;
                if (status.parent_gt)
                    heap_wd = heap_rd;
            end
            phast_pkg::OP_SW0: dist_ra = sw_reg[phast_pkg::NODE_W-1:0];
            phast_pkg::OP_SW1: dn_off_ra = sw_reg + 1'b1;
            phast_pkg::OP_D0:
            begin
                dist_we = status.edge_end;
                dist_wa = sw_reg[phast_pkg::NODE_W-1:0];
                dist_wd = di_reg;
            end
            phast_pkg::OP_D1:  dist_ra = dn_edge_rd.node;
            phast_pkg::OP_T1:  dist_ra = tgt_rd;
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (up_off_we)
            up_off_mem[item.node_id] <= item.edge_offset;
        up_off_rd <= up_off_mem[up_off_ra];
    end

    always_ff @(posedge clk)
    begin
        if (dn_off_we)
            dn_off_mem[item.node_id] <= item.edge_offset;
        dn_off_rd <= dn_off_mem[dn_off_ra];
    end

    always_ff @(posedge clk)
    begin
        if (up_edge_we)
            up_edge_mem[item.edge_slot] <= '{node: item.neighbor, weight: item.weight};
        up_edge_rd <= up_edge_mem[up_edge_ra];
    end

    always_ff @(posedge clk)
    begin
        if (dn_edge_we)
            dn_edge_mem[item.edge_slot] <= '{node: item.neighbor, weight: item.weight};
        dn_edge_rd <= dn_edge_mem[dn_edge_ra];
    end

    always_ff @(posedge clk)
    begin
        if (tgt_we)
            tgt_mem[item.target_pos] <= item.target_node;
        tgt_rd <= tgt_mem[tgt_ra];
    end

    always_ff @(posedge clk)
    begin
        if (dist_we)
            dist_mem[dist_wa] <= dist_wd;
        dist_rd <= dist_mem[dist_ra];
    end

    always_ff @(posedge clk)
    begin
        if (heap_we)
            heap_mem[heap_wa] <= heap_wd;
        heap_rd <= heap_mem[heap_ra];
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg   <= phast_pkg::NODE_ID_W'(phast_pkg::MAX_NODES);
            target_count_reg <= phast_pkg::TCNT_W'(1);
            hsize_reg        <= '0;
            clr_reg          <= '0;
            k_reg            <= '0;
            sw_reg           <= '0;
            res_valid_reg    <= 1'b0;
        end
        else
        begin
            res_valid_reg <= 1'b0;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    phast_pkg::CFG_NODE_COUNT:   node_count_reg <= cfg_data;
                    phast_pkg::CFG_TARGET_COUNT:
                        target_count_reg <= cfg_data[phast_pkg::TCNT_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
            unique case (cmd.op)
                phast_pkg::OP_CLEAR: clr_reg <= clr_reg + 1'b1;
                phast_pkg::OP_INIT:
                begin
                    hsize_reg <= ({1'b0, src_reg} < n_reg) ? phast_pkg::HEAP_AW'(1) : '0;
                    sw_reg    <= '0;
                    k_reg     <= '0;
                end
                phast_pkg::OP_POP1: hsize_reg <= hsize_reg - 1'b1;
                phast_pkg::OP_E2:
                    if (status.go_push)
                        hsize_reg <= hsize_reg + 1'b1;
                phast_pkg::OP_D0:
                    if (status.edge_end)
                        sw_reg <= sw_reg + 1'b1;
                phast_pkg::OP_T1:
                    if (status.foreign)
                    begin
                        res_valid_reg <= 1'b1;
                        k_reg         <= k_reg + 1'b1;
                    end
                phast_pkg::OP_T2:
                begin
                    res_valid_reg <= 1'b1;
                    k_reg         <= k_reg + 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            phast_pkg::OP_LOAD:
            begin
                src_reg <= item.source_node;
                n_reg   <= clamp_n;
                tc_reg  <= clamp_tc;
            end
            phast_pkg::OP_POP1:
            begin
                wkey_reg <= heap_rd.key;
                v_reg    <= heap_rd.node;
            end
            phast_pkg::OP_POP2:
            begin
                hk_reg <= heap_rd.key;
                hn_reg <= heap_rd.node;
                hi_reg <= '0;
            end
            phast_pkg::OP_SD1:
            begin
                cl_reg   <= heap_rd;
                hasr_reg <= status.sd_hasr;
            end
            phast_pkg::OP_SD2: cr_reg <= heap_rd;
            phast_pkg::OP_SD3:
            begin
                if (pick_r)
                    hi_reg <= r_w[phast_pkg::HEAP_AW-1:0];
                else if (pick_l)
                    hi_reg <= l_w[phast_pkg::HEAP_AW-1:0];
            end
            phast_pkg::OP_DV1: dv_reg <= dist_rd;
            phast_pkg::OP_UO1: e_reg <= up_off_rd;
            phast_pkg::OP_UO2, phast_pkg::OP_SW2:
                ee_reg <= (end_w > phast_pkg::OFF_W'(phast_pkg::MAX_EDGES)) ?
                          phast_pkg::OFF_W'(phast_pkg::MAX_EDGES) : end_w;
            phast_pkg::OP_E1:
            begin
                eh_reg <= up_edge_rd.node;
                ew_reg <= up_edge_rd.weight;
                if (status.foreign)
                    e_reg <= e_reg + 1'b1;
            end
            phast_pkg::OP_E2:
            begin
                e_reg <= e_reg + 1'b1;
                if (status.go_push)
                begin
                    hi_reg <= hsize_reg;
                    hk_reg <= c_up;
                    hn_reg <= eh_reg;
                end
            end
            phast_pkg::OP_PU1:
                if (status.parent_gt)
                    hi_reg <= p_w;
            phast_pkg::OP_SW1:
            begin
                e_reg  <= dn_off_rd;
                di_reg <= dist_rd;
            end
            phast_pkg::OP_D1:
            begin
                eh_reg <= dn_edge_rd.node;
                ew_reg <= dn_edge_rd.weight;
                e_reg  <= e_reg + 1'b1;
            end
            phast_pkg::OP_D2:
                if (dt_w != phast_pkg::DIST_INF && c_dn < di_reg)
                    di_reg <= c_dn;
            phast_pkg::OP_T1:
            begin
                res_reg.result_pos  <= k_reg[phast_pkg::TPOS_W-1:0];
                res_reg.distance    <= '0;
                res_reg.unreachable <= 1'b1;
                res_reg.last        <= (phast_pkg::TCNT_W'(k_reg + 1'b1) == tc_reg);
            end
            phast_pkg::OP_T2:
            begin
                res_reg.result_pos  <= k_reg[phast_pkg::TPOS_W-1:0];
                res_reg.distance    <= (dist_rd == phast_pkg::DIST_INF) ? '0 : dist_rd;
                res_reg.unreachable <= (dist_rd == phast_pkg::DIST_INF);
                res_reg.last        <= (phast_pkg::TCNT_W'(k_reg + 1'b1) == tc_reg);
            end
            default:
            begin
            end
        endcase
    end

endmodule

// File: test/phast_one_to_many_shortest_path_top_tb.sv
// Self-checking testbench for the contracted-graph one-to-many distance engine.
module phast_one_to_many_shortest_path_top_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import phast_pkg::*;

    localparam int CYCLE_LIMIT  = 3000000;
    localparam int SETTLE_WAIT  = 1100;
    localparam int GRAPH_NODES  = 24;
    localparam int NUM_PHASES   = 8;

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    item_t                 item;
    result_t               result;
    logic                  result_valid;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    phast_one_to_many_shortest_path_top dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .item(item),
        .result(result), .result_valid(result_valid), .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // Mirror of the block's stores and registers.
    logic [OFF_W-1:0]    up_start [0:MAX_NODES];
    logic [NODE_W-1:0]   up_head [0:MAX_EDGES-1];
    logic [WEIGHT_W-1:0] up_cost [0:MAX_EDGES-1];
    logic [OFF_W-1:0]    down_start [0:MAX_NODES];
    logic [NODE_W-1:0]   down_tail [0:MAX_EDGES-1];
    logic [WEIGHT_W-1:0] down_cost [0:MAX_EDGES-1];
    logic [NODE_W-1:0]   targets [0:MAX_TARGETS-1];
    logic [DIST_W-1:0]   best_dist [0:MAX_NODES-1];
    logic [DIST_W-1:0]   pq_key [0:HEAP_CAP-1];
    int                  pq_node [0:HEAP_CAP-1];
    int                  pq_size;
    logic [CFG_DATA_W-1:0] reg_nodes;
    logic [TCNT_W-1:0]     reg_targets;

    item_t   pending_items[$];
    result_t expected_results[$];
    int      idle_pct;
    int      errors;
    int      cycles;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [DIST_W-1:0] add_capped(logic [DIST_W-1:0] a,
                                                     logic [WEIGHT_W-1:0] w);
        logic [DIST_W:0] s;
        s = {1'b0, a} + w;
        return (s > {1'b0, DIST_CAP}) ? DIST_CAP : s[DIST_W-1:0];
    endfunction

    function automatic int capped_end(logic [OFF_W-1:0] e);
        return (e > MAX_EDGES) ? MAX_EDGES : int'(e);
    endfunction

    task automatic pq_swap(int a, int b);
        logic [DIST_W-1:0] k;
        int v;
        k = pq_key[a]; v = pq_node[a];
        pq_key[a] = pq_key[b]; pq_node[a] = pq_node[b];
        pq_key[b] = k; pq_node[b] = v;
    endtask

    task automatic pq_push(int v, logic [DIST_W-1:0] k);
        int i;
        int p;
        if (pq_size >= HEAP_CAP)
            return;
        i = pq_size;
        pq_size++;
        pq_key[i] = k;
        pq_node[i] = v;
        while (i > 0)
        begin
            p = (i - 1) / 2;
            if (pq_key[p] <= pq_key[i])
                break;
            pq_swap(p, i);
            i = p;
        end
    endtask

    task automatic pq_pop(output int v, output logic [DIST_W-1:0] k);
        int i;
        int l;
        int m;
        v = pq_node[0];
        k = pq_key[0];
        pq_size--;
        pq_key[0] = pq_key[pq_size];
        pq_node[0] = pq_node[pq_size];
        i = 0;
        forever
        begin
            l = 2 * i + 1;
            m = i;
            if (l < pq_size && pq_key[l] < pq_key[m])
                m = l;
            if (l + 1 < pq_size && pq_key[l + 1] < pq_key[m])
                m = l + 1;
            if (m == i)
                break;
            pq_swap(i, m);
            i = m;
        end
    endtask

    // Upward search, downward sweep, then one expected result per target entry.
    task automatic shortest_paths(int src);
        int n;
        int tc;
        int v;
        int h;
        int t;
        logic [DIST_W-1:0] k;
        logic [DIST_W-1:0] c;
        result_t r;
        n = (reg_nodes < 1) ? 1 : (reg_nodes > MAX_NODES) ? MAX_NODES : int'(reg_nodes);
        tc = (reg_targets < 1) ? 1 : (reg_targets > MAX_TARGETS) ? MAX_TARGETS
                                                                 : int'(reg_targets);
        pq_size = 0;
        if (src < n)
        begin
            best_dist[src] = '0;
            pq_push(src, '0);
        end
        while (pq_size > 0)
        begin
            pq_pop(v, k);
            if (k > best_dist[v])
                continue;
            for (int e = up_start[v]; e < capped_end(up_start[v + 1]); e++)
            begin
                h = up_head[e];
                if (h >= n)
                    continue;
                c = add_capped(best_dist[v], up_cost[e]);
                if (c < best_dist[h])
                begin
                    best_dist[h] = c;
                    pq_push(h, c);
                end
            end
        end
        for (int i = 0; i < n; i++)
        begin
            for (int e = down_start[i]; e < capped_end(down_start[i + 1]); e++)
            begin
                t = down_tail[e];
                if (t >= n || best_dist[t] == DIST_INF)
                    continue;
                c = add_capped(best_dist[t], down_cost[e]);
                if (c < best_dist[i])
                    best_dist[i] = c;
            end
        end
        for (int j = 0; j < tc; j++)
        begin
            t = targets[j];
            r.result_pos = j;
            r.unreachable = (t >= n) || (best_dist[t] == DIST_INF);
            r.distance = r.unreachable ? '0 : best_dist[t];
            r.last = (j + 1 == tc);
            expected_results.push_back(r);
        end
        for (int i = 0; i < MAX_NODES; i++)
            best_dist[i] = DIST_INF;
    endtask

    task automatic predict_item(item_t it);
        case (it.kind)
            KIND_UP_OFFSET:
                if (it.node_id <= MAX_NODES)
                    up_start[it.node_id] = it.edge_offset;
            KIND_UP_EDGE:
            begin
                up_head[it.edge_slot] = it.neighbor;
                up_cost[it.edge_slot] = it.weight;
            end
            KIND_DOWN_OFFSET:
                if (it.node_id <= MAX_NODES)
                    down_start[it.node_id] = it.edge_offset;
            KIND_DOWN_EDGE:
            begin
                down_tail[it.edge_slot] = it.neighbor;
                down_cost[it.edge_slot] = it.weight;
            end
            KIND_TARGET:
                targets[it.target_pos] = it.target_node;
            KIND_QUERY:
                shortest_paths(it.source_node);
            default: ;
        endcase
    endtask

    // Every field but the kind gets random content; the caller overrides what matters.
    function automatic item_t rand_item(logic [2:0] k);
        item_t it;
        it.kind = k;
        it.node_id = $urandom;
        it.edge_offset = $urandom;
        it.edge_slot = $urandom;
        it.neighbor = $urandom;
        it.weight = $urandom;
        it.target_pos = $urandom;
        it.target_node = $urandom;
        it.source_node = $urandom;
        return it;
    endfunction

    function automatic logic [WEIGHT_W-1:0] rand_weight();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2, 3: return $urandom;
            default: return $urandom_range(0, 32'h0004_0000);
        endcase
    endfunction

    task automatic add_offset(logic [2:0] k, int node, int off);
        item_t it;
        it = rand_item(k);
        it.node_id = node;
        it.edge_offset = off;
        pending_items.push_back(it);
    endtask

    task automatic add_edge(logic [2:0] k, int slot, int nb, logic [WEIGHT_W-1:0] w);
        item_t it;
        it = rand_item(k);
        it.edge_slot = slot;
        it.neighbor = nb;
        it.weight = w;
        pending_items.push_back(it);
    endtask

    task automatic add_target(int pos, int node);
        item_t it;
        it = rand_item(KIND_TARGET);
        it.target_pos = pos;
        it.target_node = node;
        pending_items.push_back(it);
    endtask

    task automatic add_query(int src);
        item_t it;
        it = rand_item(KIND_QUERY);
        it.source_node = src;
        pending_items.push_back(it);
    endtask

    // One adjacency store laid out as consecutive runs, now and then with an empty
    // or backward run, in a random region of the edge store.
    task automatic build_store(logic [2:0] off_kind, logic [2:0] edge_kind, int n);
        int base;
        int pos;
        int cnt;
        base = $urandom_range(0, MAX_EDGES - 200);
        pos = base;
        for (int i = 0; i <= n; i++)
        begin
            if ($urandom_range(0, 9) == 0 && pos >= 2)
                pos = pos - 2;
            add_offset(off_kind, i, pos);
            if (i < n)
            begin
                cnt = $urandom_range(0, 4);
                for (int e = 0; e < cnt; e++)
                    add_edge(edge_kind, pos + e, $urandom_range(0, n + n / 4), rand_weight());
                pos = pos + cnt;
            end
        end
    endtask

    task automatic build_phase(int n, int nodes_raw);
        int nq;
        build_store(KIND_UP_OFFSET, KIND_UP_EDGE, n);
        build_store(KIND_DOWN_OFFSET, KIND_DOWN_EDGE, n);
        for (int j = 0; j < 12; j++)
            add_target($urandom_range(0, MAX_TARGETS - 1),
                       ($urandom_range(0, 5) == 0) ? $urandom_range(0, MAX_NODES - 1)
                                                   : $urandom_range(0, n));
        nq = $urandom_range(3, 5);
        for (int q = 0; q < nq; q++)
        begin
            // Ignored noise: unused kinds and offset loads beyond the end slot.
            if ($urandom_range(0, 1) == 0)
                pending_items.push_back(rand_item($urandom_range(6, 7)));
            else
                add_offset($urandom_range(0, 1) ? KIND_UP_OFFSET : KIND_DOWN_OFFSET,
                           $urandom_range(MAX_NODES + 1, 2047), $urandom);
            add_query(($urandom_range(0, 7) == 0) ? $urandom_range(0, MAX_NODES - 1)
                                                  : $urandom_range(0, n));
        end
    endtask

    task automatic settle();
        do
            @(posedge clk);
        while (pending_items.size() != 0 || start || expected_results.size() != 0);
        repeat (SETTLE_WAIT) @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_NODE_COUNT)
            reg_nodes = value;
        else
            reg_targets = value[TCNT_W-1:0];
    endtask

    // Driver: a transfer happens at an edge where start is high and busy is low.
    always @(posedge clk)
    begin
        if (!rst_n)
            start <= 1'b0;
        else if (!start || !busy)
        begin
            if (start)
            begin
                predict_item(item);
                void'(pending_items.pop_front());
            end
            if (pending_items.size() != 0 && $urandom_range(0, 99) >= idle_pct)
            begin
                start <= 1'b1;
                item <= pending_items[0];
            end
            else
                start <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid)
        begin
            if (expected_results.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result %p", $time, result);
            end
            else
            begin
                result_t want;
                want = expected_results.pop_front();
                if (result.result_pos !== want.result_pos)
                begin
                    errors++;
                    $display("%0t: result_pos expected %0d actual %0d", $time,
                             want.result_pos, result.result_pos);
                end
                if (result.distance !== want.distance)
                begin
                    errors++;
                    $display("%0t: distance expected %h actual %h", $time,
                             want.distance, result.distance);
                end
                if (result.unreachable !== want.unreachable)
                begin
                    errors++;
                    $display("%0t: unreachable expected %b actual %b", $time,
                             want.unreachable, result.unreachable);
                end
                if (result.last !== want.last)
                begin
                    errors++;
                    $display("%0t: last expected %b actual %b", $time,
                             want.last, result.last);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        int nodes_set [NUM_PHASES];
        int tgts_set [NUM_PHASES];
        int idle_set [3];
        int n;
        nodes_set = '{1, 16, 0, 2047, 1024, 37, 5, 1024};
        tgts_set = '{1, 64, 0, 127, 64, 20, 7, 3};
        idle_set = '{0, 45, 6};
        rst_n = 1'b0;
        start = 1'b0;
        item = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        errors = 0;
        cycles = 0;
        idle_pct = 0;
        reg_nodes = MAX_NODES;
        reg_targets = 1;
        for (int i = 0; i < MAX_NODES; i++)
            best_dist[i] = DIST_INF;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Define every store entry so that no later read hits an unwritten one.
        for (int i = 0; i <= MAX_NODES; i++)
        begin
            add_offset(KIND_UP_OFFSET, i, 0);
            add_offset(KIND_DOWN_OFFSET, i, 0);
        end
        for (int s = 0; s < MAX_EDGES; s++)
        begin
            add_edge(KIND_UP_EDGE, s, $urandom_range(0, MAX_NODES - 1),
                     (s == 0) ? '0 : (s == 1) ? '1 : rand_weight());
            add_edge(KIND_DOWN_EDGE, s, $urandom_range(0, MAX_NODES - 1), rand_weight());
        end
        for (int j = 0; j < MAX_TARGETS; j++)
            add_target(j, $urandom_range(0, MAX_NODES - 1));

        // Short directed part at the reset register values.
        add_query(0);
        add_target(0, MAX_NODES - 1);
        pending_items.push_back(rand_item(3'd6));
        pending_items.push_back(rand_item(3'd7));
        add_offset(KIND_UP_OFFSET, MAX_NODES + 1, 5);
        add_offset(KIND_DOWN_OFFSET, 2047, 7);
        // A full-length run from the last node reaches most of the graph.
        add_offset(KIND_UP_OFFSET, MAX_NODES, MAX_EDGES);
        add_offset(KIND_DOWN_OFFSET, MAX_NODES, MAX_EDGES);
        add_offset(KIND_UP_OFFSET, MAX_NODES - 1, 0);
        add_query(MAX_NODES - 1);
        add_target(0, 3);
        add_query(MAX_NODES - 1);
        add_query(1);
        settle();

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            write_reg(CFG_NODE_COUNT, nodes_set[p]);
            write_reg(CFG_TARGET_COUNT, tgts_set[p]);
            idle_pct = idle_set[p % 3];
            n = (nodes_set[p] < 1) ? 1 : (nodes_set[p] > GRAPH_NODES) ? GRAPH_NODES
                                                                    : nodes_set[p];
            build_phase(n, nodes_set[p]);
            settle();
        end

        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// File: sim.f
sv/phast_pkg.sv
sv/phast_ctrl.sv
sv/phast_dp.sv
sv/phast_one_to_many_shortest_path_top.sv
test/phast_one_to_many_shortest_path_top_tb.sv
